FILE: hw/rtl/gbm_pkg.sv
// Shared types, constants and register indexes of the Goertzel bin magnitude block.
`default_nettype none

package gbm_pkg;

    // Field widths of the sample and result transactions
    localparam int SAMPLE_BITS   = 16;
    localparam int MAG_BITS      = 40;
    localparam int ACC_BITS_DEF  = 40;

    // Coefficient formats (Q14)
    localparam int COEFF_BITS    = 17;
    localparam int TERM_BITS     = 16;
    localparam int Q_FRAC        = 14;
    localparam int ROUND_HALF    = 1 << (Q_FRAC - 1);

    // Frame queue between recursion and magnitude engine
    localparam int QUEUE_DEPTH   = 2;

    // Configuration port
    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 32;

    localparam logic signed [COEFF_BITS-1:0] COEFF_RESET = '0;
    localparam logic signed [TERM_BITS-1:0]  COS_RESET   = 16'sd16384;
    localparam logic signed [TERM_BITS-1:0]  SIN_RESET   = '0;

    typedef enum logic [1:0] {
        REG_COEFF = 2'd0,
        REG_COS   = 2'd1,
        REG_SIN   = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last_sample;
    } t_in_item;

    typedef struct packed {
        logic [MAG_BITS-1:0] magnitude;
        logic                overflow;
    } t_out_item;

    typedef struct packed {
        logic signed [COEFF_BITS-1:0] coeff;
        logic signed [TERM_BITS-1:0]  cos_term;
        logic signed [TERM_BITS-1:0]  sin_term;
    } t_cfg;

endpackage

`default_nettype wire

FILE: hw/rtl/goertzel_bin_magnitude.sv
// Goertzel single-bin detector: sample recursion, frame queue and magnitude engine.
// The front end takes a sample and registers its coefficient multiply, then updates
//   the accumulators before it takes the next; the magnitude engine works on one frame
//   at a time, and its bit-serial square root, one bit per cycle, dominates the time
//   from the last sample of a frame to its result.
// Synchronous active-low reset clears accumulators, queue and sequencers and
//   loads the coefficient registers with their reset values.
`default_nettype none

module goertzel_bin_magnitude #(
    parameter int ACC_BITS = gbm_pkg::ACC_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire gbm_pkg::t_in_item                 i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output gbm_pkg::t_out_item                     o_out_data,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [gbm_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [gbm_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic      [gbm_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                                   pready
);
    import gbm_pkg::*;

    localparam int QW = 2 * ACC_BITS + 1;

    t_cfg          r_cfg;
    t_reg_idx      reg_idx;
    logic          cfg_wr;
    logic          q_push;
    logic [QW-1:0] q_push_data;
    logic          q_pop;
    logic [QW-1:0] q_pop_data;
    logic          q_full;
    logic          q_empty;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[CFG_ADDR_BITS-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Write coefficient registers; unmapped addresses drop the transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coeff    <= COEFF_RESET;
            r_cfg.cos_term <= COS_RESET;
            r_cfg.sin_term <= SIN_RESET;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_COEFF: r_cfg.coeff    <= pwdata[COEFF_BITS-1:0];
                REG_COS:   r_cfg.cos_term <= pwdata[TERM_BITS-1:0];
                REG_SIN:   r_cfg.sin_term <= pwdata[TERM_BITS-1:0];
                default:   r_cfg          <= r_cfg;
            endcase
        end
    end

    // Read back register contents
    always_comb begin
        case (reg_idx)
            REG_COEFF: prdata = CFG_DATA_BITS'(unsigned'(r_cfg.coeff));
            REG_COS:   prdata = CFG_DATA_BITS'(unsigned'(r_cfg.cos_term));
            REG_SIN:   prdata = CFG_DATA_BITS'(unsigned'(r_cfg.sin_term));
            default:   prdata = '0;
        endcase
    end

    gbm_front #(
        .ACC_BITS (ACC_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_cfg       (r_cfg),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    gbm_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .i_pop       (q_pop),
        .o_pop_data  (q_pop_data),
        .o_full      (q_full),
        .o_empty     (q_empty)
    );

    gbm_back #(
        .ACC_BITS (ACC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_empty   (q_empty),
        .i_pop_data  (q_pop_data),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/gbm_queue.sv
// Small register FIFO that carries finished frame accumulators to the back end.
`default_nettype none

module gbm_queue #(
    parameter int WIDTH = 81,
    parameter int DEPTH = gbm_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_push_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_pop_data,
    output logic                  o_full,
    output logic                  o_empty
);
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full     = (r_count == CNT_BITS'(DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_mem[r_rd_ptr];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && !o_empty;

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!do_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/gbm_front.sv
// Front end: takes samples and runs the saturating Goertzel recursion.
`default_nettype none

module gbm_front #(
    parameter int ACC_BITS = gbm_pkg::ACC_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire gbm_pkg::t_in_item i_in_data,
    input  wire gbm_pkg::t_cfg     i_cfg,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output logic [2*ACC_BITS:0]    o_push_data
);
    import gbm_pkg::*;

    localparam int PW = ACC_BITS + COEFF_BITS;
    localparam int SW = ACC_BITS + 5;

    typedef enum logic [1:0] {
        F_TAKE = 2'b01,
        F_UPD  = 2'b10
    } t_fstate;

    t_fstate                       r_state;
    t_fstate                       n_state;
    logic signed [ACC_BITS-1:0]    r_q1;
    logic signed [ACC_BITS-1:0]    r_q2;
    logic                          r_sat;
    logic signed [PW-1:0]          r_prod;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic                          r_last;

    logic                          accept;
    logic signed [PW-1:0]          rnd_w;
    logic signed [SW-1:0]          q0_w;
    logic                          q0_hit;
    logic signed [ACC_BITS-1:0]    q0_sat;

    // Take a sample only in F_TAKE and when a finished frame would find room in the queue
    assign o_in_stall = (r_state != F_TAKE) || i_q_full;
    assign accept     = i_in_valid && !o_in_stall;

    // Round the product, close the recursion and clamp to the accumulator range
    always_comb begin
        rnd_w  = (r_prod + PW'(ROUND_HALF)) >>> Q_FRAC;
        q0_w   = SW'(rnd_w) - SW'(r_q2) + SW'(r_x);
        q0_hit = (q0_w[SW-1:ACC_BITS-1] != '0) && (q0_w[SW-1:ACC_BITS-1] != '1);
        if (q0_hit) begin
            q0_sat = q0_w[SW-1] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                : {1'b0, {(ACC_BITS-1){1'b1}}};
        end else begin
            q0_sat = q0_w[ACC_BITS-1:0];
        end
    end

    // Hand the frame end to the queue: newest, previous and saturation flag
    assign o_push      = (r_state == F_UPD) && r_last;
    assign o_push_data = {q0_sat, r_q1, r_sat | q0_hit};

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_TAKE: begin
                if (accept) begin
                    n_state = F_UPD;
                end
            end
            F_UPD: begin
                n_state = F_TAKE;
            end
            default: begin
                n_state = F_TAKE;
            end
        endcase
    end

    // Update accumulators; clear them after the last sample of a frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_TAKE;
            r_q1    <= '0;
            r_q2    <= '0;
            r_sat   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == F_UPD) begin
                if (r_last) begin
                    r_q1  <= '0;
                    r_q2  <= '0;
                    r_sat <= 1'b0;
                end else begin
                    r_q1  <= q0_sat;
                    r_q2  <= r_q1;
                    r_sat <= r_sat | q0_hit;
                end
            end
        end
    end

    // Capture the sample and multiply the previous accumulator by the coefficient
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prod <= PW'(r_q1) * PW'(i_cfg.coeff);
            r_x    <= i_in_data.sample;
            r_last <= i_in_data.last_sample;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/gbm_back.sv
// Back end: forms real and imaginary parts, squares them and takes the root.
`default_nettype none

module gbm_back #(
    parameter int ACC_BITS = gbm_pkg::ACC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire gbm_pkg::t_cfg      i_cfg,
    input  wire logic               i_q_empty,
    input  wire logic [2*ACC_BITS:0] i_pop_data,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output gbm_pkg::t_out_item      o_out_data
);
    import gbm_pkg::*;

    localparam int PB       = ACC_BITS + TERM_BITS;
    localparam int SB       = ACC_BITS + 3;
    localparam int H        = (ACC_BITS + 1) / 2;
    localparam int RADW     = 2 * ACC_BITS;
    localparam int EW       = 2 * ACC_BITS + 2;
    localparam int CW       = $clog2(ACC_BITS);
    localparam int SQ_STEPS = 6;
    localparam int RW       = (ACC_BITS > MAG_BITS) ? ACC_BITS : MAG_BITS;

    typedef enum logic [5:0] {
        B_IDLE = 6'b000001,
        B_MUL  = 6'b000010,
        B_RI   = 6'b000100,
        B_SQ   = 6'b001000,
        B_ROOT = 6'b010000,
        B_OUT  = 6'b100000
    } t_bstate;

    typedef enum logic [1:0] {
        SH_LOW  = 2'd0,
        SH_MID  = 2'd1,
        SH_HIGH = 2'd2
    } t_shift;

    t_bstate                    r_state;
    t_bstate                    n_state;
    logic [CW-1:0]              r_cnt;
    logic signed [ACC_BITS-1:0] r_q1;
    logic signed [ACC_BITS-1:0] r_q2;
    logic                       r_sat;
    logic                       r_hit;
    logic signed [PB-1:0]       r_pc;
    logic signed [PB-1:0]       r_ps;
    logic [ACC_BITS-1:0]        r_abs_re;
    logic [ACC_BITS-1:0]        r_abs_im;
    logic [2*H-1:0]             r_pp;
    t_shift                     r_sh;
    logic [RADW-1:0]            r_rad;
    logic [ACC_BITS+1:0]        r_rem;
    logic [ACC_BITS-1:0]        r_root;
    logic                       r_out_valid;
    t_out_item                  r_out_data;

    logic signed [PB-1:0]       rnd_c;
    logic signed [PB-1:0]       rnd_s;
    logic signed [SB-1:0]       re_w;
    logic signed [SB-1:0]       im_w;
    logic                       re_hit;
    logic                       im_hit;
    logic [ACC_BITS-1:0]        re_sat;
    logic [ACC_BITS-1:0]        im_sat;
    logic [H-1:0]               op_a;
    logic [H-1:0]               op_b;
    t_shift                     op_sh;
    logic [EW-1:0]              addend;
    logic [ACC_BITS+1:0]        rem_sh;
    logic [ACC_BITS+1:0]        trial;
    logic [RW-1:0]              root_w;
    logic                       mag_over;
    logic                       out_free;

    assign o_pop       = (r_state == B_IDLE) && !i_q_empty;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign out_free    = !r_out_valid || !i_out_stall;

    // Round the term products and clamp real and imaginary parts
    always_comb begin
        rnd_c  = (r_pc + PB'(ROUND_HALF)) >>> Q_FRAC;
        rnd_s  = (r_ps + PB'(ROUND_HALF)) >>> Q_FRAC;
        re_w   = SB'(r_q1) - SB'(rnd_c);
        im_w   = SB'(rnd_s);
        re_hit = (re_w[SB-1:ACC_BITS-1] != '0) && (re_w[SB-1:ACC_BITS-1] != '1);
        im_hit = (im_w[SB-1:ACC_BITS-1] != '0) && (im_w[SB-1:ACC_BITS-1] != '1);
        if (re_hit) begin
            re_sat = re_w[SB-1] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                : {1'b0, {(ACC_BITS-1){1'b1}}};
        end else begin
            re_sat = re_w[ACC_BITS-1:0];
        end
        if (im_hit) begin
            im_sat = im_w[SB-1] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                : {1'b0, {(ACC_BITS-1){1'b1}}};
        end else begin
            im_sat = im_w[ACC_BITS-1:0];
        end
    end

    // Pick the half-word pair for this squaring step
    always_comb begin
        case (r_cnt)
            CW'(0): begin
                op_a = H'(r_abs_re >> H); op_b = H'(r_abs_re >> H); op_sh = SH_HIGH;
            end
            CW'(1): begin
                op_a = H'(r_abs_re >> H); op_b = r_abs_re[H-1:0]; op_sh = SH_MID;
            end
            CW'(2): begin
                op_a = r_abs_re[H-1:0]; op_b = r_abs_re[H-1:0]; op_sh = SH_LOW;
            end
            CW'(3): begin
                op_a = H'(r_abs_im >> H); op_b = H'(r_abs_im >> H); op_sh = SH_HIGH;
            end
            CW'(4): begin
                op_a = H'(r_abs_im >> H); op_b = r_abs_im[H-1:0]; op_sh = SH_MID;
            end
            CW'(5): begin
                op_a = r_abs_im[H-1:0]; op_b = r_abs_im[H-1:0]; op_sh = SH_LOW;
            end
            default: begin
                op_a = '0; op_b = '0; op_sh = SH_LOW;
            end
        endcase
    end

    // Align the registered partial product; the cross term counts twice
    always_comb begin
        case (r_sh)
            SH_LOW:  addend = EW'(r_pp);
            SH_MID:  addend = EW'(r_pp) << (H + 1);
            SH_HIGH: addend = EW'(r_pp) << (2 * H);
            default: addend = '0;
        endcase
    end

    // One root bit per cycle: bring down two radicand bits and try the next bit
    assign rem_sh = {r_rem[ACC_BITS-1:0], r_rad[RADW-1:RADW-2]};
    assign trial  = {r_root, 2'b01};

    // Clamp the root to the magnitude field
    assign root_w   = RW'(r_root);
    assign mag_over = (root_w >> MAG_BITS) != '0;

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    n_state = B_MUL;
                end
            end
            B_MUL: begin
                n_state = B_RI;
            end
            B_RI: begin
                n_state = B_SQ;
            end
            B_SQ: begin
                if (r_cnt == CW'(SQ_STEPS)) begin
                    n_state = B_ROOT;
                end
            end
            B_ROOT: begin
                if (r_cnt == CW'(ACC_BITS - 1)) begin
                    n_state = B_OUT;
                end
            end
            B_OUT: begin
                if (out_free) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    // Sequence control and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                B_RI: begin
                    r_cnt <= '0;
                end
                B_SQ: begin
                    r_cnt <= (r_cnt == CW'(SQ_STEPS)) ? '0 : r_cnt + 1'b1;
                end
                B_ROOT: begin
                    r_cnt <= r_cnt + 1'b1;
                end
                default: begin
                    r_cnt <= r_cnt;
                end
            endcase
            if ((r_state == B_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_q1  <= i_pop_data[2*ACC_BITS:ACC_BITS+1];
                r_q2  <= i_pop_data[ACC_BITS:1];
                r_sat <= i_pop_data[0];
            end
            B_MUL: begin
                r_pc <= PB'(r_q2) * PB'(i_cfg.cos_term);
                r_ps <= PB'(r_q2) * PB'(i_cfg.sin_term);
            end
            B_RI: begin
                r_hit    <= re_hit | im_hit;
                r_abs_re <= re_sat[ACC_BITS-1] ? (~re_sat + 1'b1) : re_sat;
                r_abs_im <= im_sat[ACC_BITS-1] ? (~im_sat + 1'b1) : im_sat;
                r_rad    <= '0;
            end
            B_SQ: begin
                if (r_cnt != '0) begin
                    r_rad <= r_rad + RADW'(addend);
                end
                if (r_cnt != CW'(SQ_STEPS)) begin
                    r_pp <= (2*H)'(op_a) * (2*H)'(op_b);
                    r_sh <= op_sh;
                end else begin
                    r_rem  <= '0;
                    r_root <= '0;
                end
            end
            B_ROOT: begin
                r_rad <= r_rad << 2;
                if (rem_sh >= trial) begin
                    r_rem  <= rem_sh - trial;
                    r_root <= {r_root[ACC_BITS-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_root <= {r_root[ACC_BITS-2:0], 1'b0};
                end
            end
            B_OUT: begin
                if (out_free) begin
                    r_out_data.magnitude <= mag_over ? '1 : root_w[MAG_BITS-1:0];
                    r_out_data.overflow  <= r_sat | r_hit | mag_over;
                end
            end
            default: begin
                r_rad <= r_rad;
            end
        endcase
    end

endmodule

`default_nettype wire
